FILE: src/adcmsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and register codes for the ADC mux scan averager.
// No dependencies; every other file of the block refers to this package.
package adcmsa_pkg;

    // Window, channel and sample sizing
    localparam int WINDOW_SAMPLES = 10;
    localparam int CHANNEL_COUNT  = 6;
    localparam int SAMPLE_BITS    = 12;

    localparam int WIN_IDX_W = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
    localparam int WIN_LOG   = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 0;
    localparam int SUM_W     = SAMPLE_BITS + WIN_LOG;

    // Floor divide by the window: x / W == (x * RECIP) >> SHIFT for any SUM_W-bit x,
    // with RECIP = ceil(2^SHIFT / W) and SHIFT = SUM_W + ceil(log2 W).
    localparam int DIV_SHIFT = SUM_W + WIN_LOG;
    localparam int RECIP_W   = SUM_W + 1;
    localparam longint DIV_RECIP_I =
        ((longint'(1) << DIV_SHIFT) + WINDOW_SAMPLES - 1) / WINDOW_SAMPLES;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(DIV_RECIP_I);
    localparam int DIV_PROD_W = SUM_W + RECIP_W;

    localparam logic [SUM_W-1:0] SUM_MAX =
        SUM_W'(WINDOW_SAMPLES * ((1 << SAMPLE_BITS) - 1));

    // Field widths
    localparam int CHAN_W  = 3;
    localparam int GAIN_W  = 20;
    localparam int SCALE_PROD_W = SAMPLE_BITS + GAIN_W;

    // Channel roles
    localparam logic [CHAN_W-1:0] SILENT_CHANNEL  = CHAN_W'(1);
    localparam logic [CHAN_W-1:0] VOLTAGE_CHANNEL = CHAN_W'(5);
    localparam logic [CHAN_W-1:0] LAST_CHANNEL    = CHAN_W'(CHANNEL_COUNT - 1);
    localparam logic [GAIN_W-1:0] VOLTAGE_RESET_MV = GAIN_W'(3140);

    // Configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_GAIN = CFG_IDX_W'(1);
    localparam logic [GAIN_W-1:0] CURRENT_GAIN_RST = GAIN_W'(33000);
    localparam logic [GAIN_W-1:0] VOLTAGE_GAIN_RST = GAIN_W'(333300);

    // Input item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef struct packed {
        logic                   wr;
        logic [SAMPLE_BITS-1:0] sample;
    } t_ring_wr;

    typedef struct packed {
        logic [GAIN_W-1:0] current_gain;
        logic [GAIN_W-1:0] voltage_gain;
    } t_gains;

    typedef struct packed {
        logic [CHAN_W-1:0]      measured_channel;
        logic [SAMPLE_BITS-1:0] average_code;
        logic [GAIN_W-1:0]      scaled_value;
        logic                   value_stored;
        logic [CHAN_W-1:0]      next_select;
    } t_result;

endpackage
`default_nettype wire

FILE: src/adcmsa_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on adcmsa_pkg for field widths.
interface adcmsa_in_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic [adcmsa_pkg::SAMPLE_BITS-1:0] adc_sample;
    modport source (output valid, output kind, output adc_sample, input ready);
    modport sink   (input valid, input kind, input adc_sample, output ready);
endinterface

interface adcmsa_out_if;
    logic                               valid;
    logic                               ready;
    logic [adcmsa_pkg::CHAN_W-1:0]      measured_channel;
    logic [adcmsa_pkg::SAMPLE_BITS-1:0] average_code;
    logic [adcmsa_pkg::GAIN_W-1:0]      scaled_value;
    logic                               value_stored;
    logic [adcmsa_pkg::CHAN_W-1:0]      next_select;
    modport source (output valid, output measured_channel, output average_code,
                    output scaled_value, output value_stored, output next_select,
                    input ready);
    modport sink   (input valid, input measured_channel, input average_code,
                    input scaled_value, input value_stored, input next_select,
                    output ready);
endinterface

interface adcmsa_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [adcmsa_pkg::CFG_IDX_W-1:0] index;
    logic [adcmsa_pkg::GAIN_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: src/adcmsa_ring.sv
`timescale 1ns / 1ps
`default_nettype none
// Sample ring with running sum and reciprocal-multiply window average.
// Depends on adcmsa_pkg.
module adcmsa_ring (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire adcmsa_pkg::t_ring_wr               i_wr,
    output      logic [adcmsa_pkg::SAMPLE_BITS-1:0] o_avg
);

    logic [adcmsa_pkg::SAMPLE_BITS-1:0] r_ring [adcmsa_pkg::WINDOW_SAMPLES];
    logic [adcmsa_pkg::SUM_W-1:0]       r_sum;
    logic [adcmsa_pkg::WIN_IDX_W-1:0]   r_idx;

    logic [adcmsa_pkg::SUM_W-1:0]       n_sum;
    logic [adcmsa_pkg::WIN_IDX_W-1:0]   n_idx;
    logic [adcmsa_pkg::DIV_PROD_W-1:0]  w_prod;

    // Replace the oldest code and keep the sum exact
    always_comb begin
        n_sum = r_sum - adcmsa_pkg::SUM_W'(r_ring[r_idx])
                      + adcmsa_pkg::SUM_W'(i_wr.sample);
        if (r_idx == adcmsa_pkg::WIN_IDX_W'(adcmsa_pkg::WINDOW_SAMPLES - 1)) begin
            n_idx = '0;
        end else begin
            n_idx = r_idx + adcmsa_pkg::WIN_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < adcmsa_pkg::WINDOW_SAMPLES; k++) begin
                r_ring[k] <= '0;
            end
            r_sum <= '0;
            r_idx <= '0;
        end else if (i_wr.wr) begin
            r_ring[r_idx] <= i_wr.sample;
            r_sum         <= n_sum;
            r_idx         <= n_idx;
        end
    end

    // Floor of sum / window by multiply and shift
    assign w_prod = adcmsa_pkg::DIV_PROD_W'(r_sum) *
                    adcmsa_pkg::DIV_PROD_W'(adcmsa_pkg::DIV_RECIP);
    assign o_avg  = w_prod[adcmsa_pkg::DIV_SHIFT +: adcmsa_pkg::SAMPLE_BITS];

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx < adcmsa_pkg::WIN_IDX_W'(adcmsa_pkg::WINDOW_SAMPLES))
        else $error("ring write index out of window");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum <= adcmsa_pkg::SUM_MAX)
        else $error("ring sum exceeds window of full-scale codes");

    a_sum_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_wr.wr |=> $stable(r_sum) && $stable(r_idx))
        else $error("ring changed without a sample write");

endmodule
`default_nettype wire

FILE: src/adcmsa_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// Mux scan: select counter, gain stage, channel value registers, result register.
// Depends on adcmsa_pkg.
module adcmsa_scan (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_tick,
    input  wire logic [adcmsa_pkg::SAMPLE_BITS-1:0] i_avg,
    input  wire adcmsa_pkg::t_gains                 i_gains,
    output      logic                               o_tick_ready,
    output      logic                               o_valid,
    input  wire logic                               i_ready,
    output      adcmsa_pkg::t_result                o_res
);

    logic [adcmsa_pkg::CHAN_W-1:0]      r_mux;
    logic                               r_b_valid;
    logic [adcmsa_pkg::CHAN_W-1:0]      r_b_chan;
    logic [adcmsa_pkg::CHAN_W-1:0]      r_b_next;
    logic [adcmsa_pkg::SAMPLE_BITS-1:0] r_b_avg;
    logic                               r_o_valid;
    adcmsa_pkg::t_result                r_o;
    logic [adcmsa_pkg::GAIN_W-1:0]      r_chan_val [adcmsa_pkg::CHANNEL_COUNT];

    logic [adcmsa_pkg::CHAN_W-1:0]       n_mux;
    logic [adcmsa_pkg::GAIN_W-1:0]       w_gain;
    logic [adcmsa_pkg::SCALE_PROD_W-1:0] w_prod;
    adcmsa_pkg::t_result                 n_res;
    logic                                w_out_ready;
    logic                                w_fire_b;

    assign w_out_ready  = !r_o_valid || i_ready;
    assign w_fire_b     = r_b_valid && w_out_ready;
    assign o_tick_ready = !r_b_valid || w_out_ready;

    assign n_mux = (r_mux == adcmsa_pkg::LAST_CHANNEL) ? '0
                                                       : r_mux + adcmsa_pkg::CHAN_W'(1);

    // Select gain and scale the average
    always_comb begin
        w_gain = (r_b_chan == adcmsa_pkg::VOLTAGE_CHANNEL) ? i_gains.voltage_gain
                                                           : i_gains.current_gain;
        w_prod = adcmsa_pkg::SCALE_PROD_W'(r_b_avg) * adcmsa_pkg::SCALE_PROD_W'(w_gain);
        n_res.measured_channel = r_b_chan;
        n_res.average_code     = r_b_avg;
        n_res.next_select      = r_b_next;
        if (r_b_chan == adcmsa_pkg::SILENT_CHANNEL) begin
            n_res.scaled_value = '0;
            n_res.value_stored = 1'b0;
        end else begin
            n_res.scaled_value = w_prod[adcmsa_pkg::SAMPLE_BITS +: adcmsa_pkg::GAIN_W];
            n_res.value_stored = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mux     <= '0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            for (int k = 0; k < adcmsa_pkg::CHANNEL_COUNT; k++) begin
                if (adcmsa_pkg::CHAN_W'(k) == adcmsa_pkg::VOLTAGE_CHANNEL) begin
                    r_chan_val[k] <= adcmsa_pkg::VOLTAGE_RESET_MV;
                end else begin
                    r_chan_val[k] <= '0;
                end
            end
        end else begin
            if (i_tick) begin
                r_mux     <= n_mux;
                r_b_valid <= 1'b1;
                r_b_chan  <= r_mux;
                r_b_next  <= n_mux;
                r_b_avg   <= i_avg;
            end else if (w_fire_b) begin
                r_b_valid <= 1'b0;
            end
            if (w_fire_b) begin
                r_o_valid <= 1'b1;
                r_o       <= n_res;
                if (n_res.value_stored) begin
                    r_chan_val[r_b_chan] <= n_res.scaled_value;
                end
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_o;

    a_value_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o.value_stored |->
            r_chan_val[r_o.measured_channel] == r_o.scaled_value)
        else $error("channel value register disagrees with reported result");

    a_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o.value_stored |->
            r_o.measured_channel == adcmsa_pkg::SILENT_CHANNEL && r_o.scaled_value == '0)
        else $error("unstored result on a storing channel or nonzero value");

    a_next_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o.measured_channel == adcmsa_pkg::LAST_CHANNEL &&
                       r_o.next_select == '0) ||
                      (r_o.measured_channel != adcmsa_pkg::LAST_CHANNEL &&
                       r_o.next_select == r_o.measured_channel + adcmsa_pkg::CHAN_W'(1)))
        else $error("next select does not follow measured channel");

    a_tick_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick |-> o_tick_ready)
        else $error("tick issued while gain stage is blocked");

endmodule
`default_nettype wire

FILE: src/adc_mux_scan_averager_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the ADC mux scan averager: input register, gain registers,
// sample ring and scan stage. Depends on adcmsa_pkg, adcmsa_if, adcmsa_ring, adcmsa_scan.
//
//  channel  dir  beat carries                                      notes
//  i_in     in   kind, adc_sample                                  sample or scan tick
//  o_out    out  measured_channel, average_code, scaled_value,     one beat per tick
//                value_stored, next_select
//  i_cfg    in   index, data                                       gain writes, always ready
//
// One input beat per cycle unless a tick waits in the input register for the gain stage;
// a sample reaches the ring in the cycle after accept. A tick's result passes the input
// register, average register (divide-by-window multiply), result register (gain multiply).
// Synchronous reset clears ring, sum, indexes and all channel values but the voltage one.
// A stalled result holds the result register; samples flow past a blocked tick,
// and a further tick waits in the input register until the gain stage frees.
module adc_mux_scan_averager_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    adcmsa_in_if.sink          i_in,
    adcmsa_out_if.source       o_out,
    adcmsa_cfg_if.sink         i_cfg
);

    // Input register
    logic                               r_a_valid;
    logic                               r_a_kind;
    logic [adcmsa_pkg::SAMPLE_BITS-1:0] r_a_sample;

    // Gain registers
    logic [adcmsa_pkg::GAIN_W-1:0]      r_current_gain;
    logic [adcmsa_pkg::GAIN_W-1:0]      r_voltage_gain;

    logic                               w_tick_ready;
    logic                               w_fire_a;
    logic                               w_tick;
    logic [adcmsa_pkg::SAMPLE_BITS-1:0] w_avg;
    adcmsa_pkg::t_ring_wr               w_ring_wr;
    adcmsa_pkg::t_gains                 w_gains;
    adcmsa_pkg::t_result                w_res;
    logic                               w_out_valid;

    // Samples leave the input register unconditionally; ticks need room downstream
    assign w_fire_a = r_a_valid && ((r_a_kind == adcmsa_pkg::KIND_SAMPLE) || w_tick_ready);
    assign w_tick   = w_fire_a && (r_a_kind == adcmsa_pkg::KIND_TICK);
    assign i_in.ready = !r_a_valid || w_fire_a;

    assign w_ring_wr.wr     = w_fire_a && (r_a_kind == adcmsa_pkg::KIND_SAMPLE);
    assign w_ring_wr.sample = r_a_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_a_valid <= 1'b1;
        end else if (w_fire_a) begin
            r_a_valid <= 1'b0;
        end
        // Payload needs no reset; load on each accepted beat
        if (i_in.valid && i_in.ready) begin
            r_a_kind   <= i_in.kind;
            r_a_sample <= i_in.adc_sample;
        end
    end

    // Register writes; indexes past the list are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_gain <= adcmsa_pkg::CURRENT_GAIN_RST;
            r_voltage_gain <= adcmsa_pkg::VOLTAGE_GAIN_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == adcmsa_pkg::CFG_CURRENT_GAIN) begin
                r_current_gain <= i_cfg.data;
            end else if (i_cfg.index == adcmsa_pkg::CFG_VOLTAGE_GAIN) begin
                r_voltage_gain <= i_cfg.data;
            end
        end
    end

    assign w_gains.current_gain = r_current_gain;
    assign w_gains.voltage_gain = r_voltage_gain;

    adcmsa_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_ring_wr),
        .o_avg   (w_avg)
    );

    adcmsa_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (w_tick),
        .i_avg        (w_avg),
        .i_gains      (w_gains),
        .o_tick_ready (w_tick_ready),
        .o_valid      (w_out_valid),
        .i_ready      (o_out.ready),
        .o_res        (w_res)
    );

    assign o_out.valid            = w_out_valid;
    assign o_out.measured_channel = w_res.measured_channel;
    assign o_out.average_code     = w_res.average_code;
    assign o_out.scaled_value     = w_res.scaled_value;
    assign o_out.value_stored     = w_res.value_stored;
    assign o_out.next_select      = w_res.next_select;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !w_fire_a |=> r_a_valid && $stable(r_a_kind) && $stable(r_a_sample))
        else $error("input register lost a waiting beat");

    a_sample_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_a_kind == adcmsa_pkg::KIND_SAMPLE |-> w_fire_a)
        else $error("sample held in input register");

    a_one_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_tick && w_ring_wr.wr))
        else $error("beat routed to ring and scan together");

endmodule
`default_nettype wire
